>>> rtl/core/sample_average_ascii_report_top_assert.svh
// Assertion macros for the sample average report block.
// Expects clk and rst_n in the scope of each use.
`ifndef SAMPLE_AVERAGE_ASCII_REPORT_TOP_ASSERT_SVH
`define SAMPLE_AVERAGE_ASCII_REPORT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SAAR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("saar assertion failed");
`define SAAR_ASSERT_IMPLY(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("saar implication failed");
`else
`define SAAR_ASSERT(name, prop)
`define SAAR_ASSERT_IMPLY(name, pre, post)
`endif
`endif

>>> rtl/core/saar_pkg.sv
// Package for the sample average report block: sizes, report text, digit helpers.
// No dependencies.
`default_nettype none
package saar_pkg;

    localparam int BLOCK_SAMPLES = 32;
    localparam int SAMPLE_BITS   = 10;
    localparam int BLOCK_SHIFT   = $clog2(BLOCK_SAMPLES);
    localparam int COUNT_BITS    = $clog2(BLOCK_SAMPLES);
    localparam int SUM_BITS      = SAMPLE_BITS + BLOCK_SHIFT;
    localparam int MEAN_BITS     = SUM_BITS - BLOCK_SHIFT;
    localparam int THR_BITS      = 10;
    localparam int CMP_BITS      = (MEAN_BITS > THR_BITS) ? MEAN_BITS : THR_BITS;
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 10'h200;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int REPORT_LEN = 14;
    localparam int IDX_BITS   = $clog2(REPORT_LEN);
    localparam logic [IDX_BITS-1:0] IDX_FIRST_DIGIT = 4'd8;
    localparam logic [IDX_BITS-1:0] IDX_LAST_DIGIT  = 4'd11;
    localparam logic [IDX_BITS-1:0] IDX_LF          = 4'd12;
    localparam logic [IDX_BITS-1:0] IDX_CR          = 4'd13;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_CR   = 8'h0D;

    localparam logic [7:0] ON_TEXT [8] = '{8'h4C, 8'h45, 8'h44, 8'h20,
                                           8'h4F, 8'h4E, 8'h20, 8'h20};
    localparam logic [7:0] OFF_TEXT [8] = '{8'h4C, 8'h45, 8'h44, 8'h20,
                                            8'h4F, 8'h46, 8'h46, 8'h20};

    localparam int PLACE_VALUE [4] = '{1000, 100, 10, 1};

    typedef struct packed {
        logic [MEAN_BITS-1:0] mean;
        logic                 led_on;
    } report_req_t;

    // decimal digit of value at position pos (0 = thousands)
    function automatic logic [3:0] digit_of(input logic [MEAN_BITS-1:0] value,
                                            input logic [1:0] pos);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (int'(value) >= k * PLACE_VALUE[pos])
            begin
                d = d + 4'd1;
            end
        end
        return d;
    endfunction

    function automatic logic [MEAN_BITS-1:0] rem_after(input logic [MEAN_BITS-1:0] value,
                                                       input logic [1:0] pos,
                                                       input logic [3:0] d);
        return MEAN_BITS'(int'(value) - int'(d) * PLACE_VALUE[pos]);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/saar_ifs.sv
// Handshake channel interfaces: sample input, report output, threshold write.
// Depends on saar_pkg.
`default_nettype none
interface saar_sample_if;
    import saar_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface saar_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

interface saar_cfg_if;
    import saar_pkg::*;
    logic                valid;
    logic                ready;
    logic [THR_BITS-1:0] threshold;
    modport source (output valid, output threshold, input ready);
    modport sink (input valid, input threshold, output ready);
endinterface
`default_nettype wire

>>> rtl/core/saar_front.sv
// Front end: sample accumulation, block mean, threshold compare, queue push.
// Depends on saar_pkg and saar_ifs.
`default_nettype none
module saar_front (
    input  wire                  clk,
    input  wire                  rst_n,
    saar_sample_if.sink          samples,
    saar_cfg_if.sink             cfg,
    input  wire                  q_full,
    output logic                 push,
    output saar_pkg::report_req_t push_data
);
    import saar_pkg::*;

    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [THR_BITS-1:0]   threshold_reg;
    logic                  block_end;
    logic                  accept;

    assign block_end     = (count_reg == COUNT_BITS'(BLOCK_SAMPLES - 1));
    assign samples.ready = !(block_end && q_full);
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign sum_next      = sum_reg + SUM_BITS'(samples.sample);

    assign push             = accept && block_end;
    assign push_data.mean   = sum_next[SUM_BITS-1:BLOCK_SHIFT];
    assign push_data.led_on = CMP_BITS'(sum_next[SUM_BITS-1:BLOCK_SHIFT])
                              < CMP_BITS'(threshold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                threshold_reg <= cfg.threshold;
            end
            if (accept)
            begin
                if (block_end)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/saar_queue.sv
// Short queue of pending report requests between front and back.
// Depends on saar_pkg.
`default_nettype none
module saar_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  saar_pkg::report_req_t push_data,
    output logic                  full,
    output logic                  q_valid,
    output saar_pkg::report_req_t q_data,
    input  wire                   pop
);
    import saar_pkg::*;

    report_req_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic                  do_push, do_pop;

    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_BITS'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/saar_back.sv
// Back end: walks one report request out as 14 characters, one digit per step.
// Depends on saar_pkg, saar_ifs and the assertion macro header.
`default_nettype none
`include "sample_average_ascii_report_top_assert.svh"
module saar_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    input  saar_pkg::report_req_t q_data,
    output logic                  pop,
    saar_report_if.source         report
);
    import saar_pkg::*;

    logic                 busy_reg;
    logic                 led_on_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [MEAN_BITS-1:0] rem_reg, rem_next;
    logic                 out_valid_reg;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg;
    logic                 load;
    logic [3:0]           digit;

    assign pop   = !busy_reg && q_valid;
    assign load  = busy_reg && (!out_valid_reg || report.ready);
    assign digit = digit_of(rem_reg, idx_reg[1:0]);

    assign report.valid     = out_valid_reg;
    assign report.character = char_reg;
    assign report.last      = last_reg;

    always_comb
    begin
        rem_next = rem_reg;
        priority if (idx_reg < IDX_FIRST_DIGIT)
        begin
            char_next = led_on_reg ? ON_TEXT[idx_reg[2:0]] : OFF_TEXT[idx_reg[2:0]];
        end
        else if (idx_reg <= IDX_LAST_DIGIT)
        begin
            char_next = ASCII_ZERO + 8'(digit);
            rem_next  = rem_after(rem_reg, idx_reg[1:0], digit);
        end
        else if (idx_reg == IDX_LF)
        begin
            char_next = ASCII_LF;
        end
        else
        begin
            char_next = ASCII_CR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg    <= q_data.mean;
            led_on_reg <= q_data.led_on;
        end
        else if (load)
        begin
            rem_reg <= rem_next;
        end
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= (idx_reg == IDX_CR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + IDX_BITS'(1);
                if (idx_reg == IDX_CR)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `SAAR_ASSERT_IMPLY(a_last_is_cr, report.valid && report.last, report.character == ASCII_CR)
    `SAAR_ASSERT_IMPLY(a_pop_when_free, pop, !busy_reg && !load)
    `SAAR_ASSERT(a_digits_used_up, load && idx_reg == IDX_LAST_DIGIT |=> rem_reg == '0)

endmodule
`default_nettype wire

>>> rtl/core/sample_average_ascii_report_top.sv
// Top level of the sample average report block: front, queue, back.
// Depends on saar_pkg, saar_ifs, saar_front, saar_queue, saar_back.
//
//  channel  | dir | payload                 | request
//  samples  | in  | sample[9:0]             | one converter sample
//  report   | out | character[7:0], last    | one report character
//  cfg      | in  | threshold[9:0]          | threshold write, always ready
//
// One sample per cycle while samples.ready is high. A block of 32 samples yields 14
// characters that leave the back end after it pops their request from the queue.
// samples.ready falls only when a block-ending sample meets a full two-entry queue.
// The output register holds a character under stall while the next report is popped.
// Reset: threshold 512, sum and count zero, queue empty.
`default_nettype none
module sample_average_ascii_report_top (
    input  wire           clk,
    input  wire           rst_n,
    saar_sample_if.sink   samples,
    saar_report_if.source report,
    saar_cfg_if.sink      cfg
);
    import saar_pkg::*;

    logic        push, q_full, q_valid, pop;
    report_req_t push_data, q_data;

    saar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    saar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    saar_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .report  (report)
    );

endmodule
`default_nettype wire

>>> sim/tb_sample_average_ascii_report_top.sv
`timescale 1ns / 100ps
// Testbench for sample_average_ascii_report_top: sample blocks in, report text out.
// Checks every report character against an in-bench predictor of the block.
// Depends on saar_pkg, saar_ifs and the block's RTL.
module tb_sample_average_ascii_report_top;
    import saar_pkg::*;

    localparam int PERIOD_HALF = 2;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_LOGGED = 10;
    localparam int TAIL_SAMPLES = 6;
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int THR_MAX = (1 << THR_BITS) - 1;

    typedef enum {FILL_LEVEL, FILL_UNIFORM, FILL_NEAR, FILL_RAILS} fill_kind_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } report_char_t;

    logic clk = 1'b0;
    logic rst_n;

    saar_sample_if smp();
    saar_report_if rpt();
    saar_cfg_if    cfg_ch();

    sample_average_ascii_report_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp),
        .report  (rpt),
        .cfg     (cfg_ch)
    );

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    report_char_t           report_chars_due[$];

    logic [SUM_BITS-1:0] block_sum;
    int                  block_count;
    logic [THR_BITS-1:0] threshold_now;

    bit idle_on;
    int src_gap;
    int snk_gap;
    int cycle_count;
    int mismatch_count;
    int samples_taken;
    int chars_checked;
    int reports_due;
    int threshold_writes;

    always #(PERIOD_HALF) clk = ~clk;

    task automatic log_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_LOGGED)
        begin
            $display("%0t: %s expected 0x%02h got 0x%02h", $realtime, what, want, got);
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic is_last);
        report_char_t c;
        c.character = ch;
        c.last = is_last;
        report_chars_due.push_back(c);
    endtask

    // running sum; a full block turns into the 14-character report line
    task automatic add_sample(input logic [SAMPLE_BITS-1:0] s);
        int    mean;
        int    place;
        string led_text;
        block_sum = block_sum + SUM_BITS'(s);
        block_count++;
        if (block_count == BLOCK_SAMPLES)
        begin
            mean = int'(block_sum >> BLOCK_SHIFT);
            led_text = (mean < int'(threshold_now)) ? "LED ON  " : "LED OFF ";
            for (int i = 0; i < 8; i++)
            begin
                push_char(led_text[i], 1'b0);
            end
            place = 1000;
            for (int k = 0; k < 4; k++)
            begin
                push_char(ASCII_ZERO + 8'((mean / place) % 10), 1'b0);
                place = place / 10;
            end
            push_char(ASCII_LF, 1'b0);
            push_char(ASCII_CR, 1'b1);
            block_sum = '0;
            block_count = 0;
            reports_due++;
        end
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
            smp.sample <= '0;
            src_gap <= 0;
        end
        else if (!smp.valid || smp.ready)
        begin
            if (src_gap != 0)
            begin
                smp.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (sample_queue.size() == 0)
            begin
                smp.valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                smp.valid <= 1'b0;
                src_gap <= $urandom_range(0, 14);
            end
            else
            begin
                smp.valid <= 1'b1;
                smp.sample <= sample_queue.pop_front();
            end
        end
    end

    // report sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt.ready <= 1'b0;
            snk_gap <= 0;
        end
        else if (snk_gap != 0)
        begin
            rpt.ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rpt.ready <= 1'b0;
            snk_gap <= $urandom_range(0, 14);
        end
        else
        begin
            rpt.ready <= 1'b1;
        end
    end

    // monitor: check report characters, predict from accepted samples
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rpt.valid && rpt.ready)
            begin
                chars_checked++;
                if (report_chars_due.size() == 0)
                begin
                    log_mismatch("unexpected character", 8'h00, rpt.character);
                end
                else
                begin
                    if (rpt.character !== report_chars_due[0].character)
                    begin
                        log_mismatch("character", report_chars_due[0].character, rpt.character);
                    end
                    if (rpt.last !== report_chars_due[0].last)
                    begin
                        log_mismatch("last", 8'(report_chars_due[0].last), 8'(rpt.last));
                    end
                    void'(report_chars_due.pop_front());
                end
            end
            if (smp.valid && smp.ready)
            begin
                samples_taken++;
                add_sample(smp.sample);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                threshold_now = cfg_ch.threshold;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sample_average_ascii_report_top: mismatch");
            $finish;
        end
    end

    task automatic write_threshold(input logic [THR_BITS-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.threshold <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        threshold_writes++;
        @(negedge clk);
    endtask

    task automatic queue_samples(input fill_kind_t kind, input int count, input int level);
        int v;
        for (int i = 0; i < count; i++)
        begin
            case (kind)
                FILL_LEVEL: v = level;
                FILL_UNIFORM: v = $urandom_range(0, SAMPLE_MAX);
                FILL_NEAR: v = level + $urandom_range(0, 80) - 40;
                default: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            endcase
            if (v < 0)
            begin
                v = 0;
            end
            if (v > SAMPLE_MAX)
            begin
                v = SAMPLE_MAX;
            end
            sample_queue.push_back(SAMPLE_BITS'(v));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (sample_queue.size() != 0 || smp.valid || report_chars_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int edge_thr;
        int thr;
        smp.valid = 1'b0;
        smp.sample = '0;
        rpt.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.threshold = '0;
        block_sum = '0;
        block_count = 0;
        threshold_now = THRESHOLD_RESET;
        idle_on = 1'b1;
        cycle_count = 0;
        mismatch_count = 0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-scale block at the reset threshold
        queue_samples(FILL_LEVEL, BLOCK_SAMPLES, SAMPLE_MAX);
        drain();
        // zero block, zero threshold: mean not below it
        write_threshold('0);
        queue_samples(FILL_LEVEL, BLOCK_SAMPLES, 0);
        drain();
        // mean equal to threshold, then one below
        edge_thr = $urandom_range(1, THR_MAX - 1);
        write_threshold(THR_BITS'(edge_thr));
        queue_samples(FILL_LEVEL, BLOCK_SAMPLES, edge_thr);
        drain();
        queue_samples(FILL_LEVEL, BLOCK_SAMPLES, edge_thr - 1);
        drain();

        write_threshold(THR_BITS'(THR_MAX));
        queue_samples(FILL_UNIFORM, BLOCK_SAMPLES, 0);
        drain();

        thr = $urandom_range(0, THR_MAX);
        write_threshold(THR_BITS'(thr));
        queue_samples(FILL_NEAR, BLOCK_SAMPLES, thr);
        drain();

        idle_on = 1'b0;
        thr = $urandom_range(0, THR_MAX);
        write_threshold(THR_BITS'(thr));
        queue_samples(FILL_RAILS, BLOCK_SAMPLES, 0);
        queue_samples(FILL_UNIFORM, TAIL_SAMPLES, 0);
        drain();

        while (report_chars_due.size() != 0)
        begin
            log_mismatch("missing character", report_chars_due[0].character, 8'h00);
            void'(report_chars_due.pop_front());
        end

        $display("%0d samples in %0d reports, %0d characters checked, %0d threshold writes",
                 samples_taken, reports_due, chars_checked, threshold_writes);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("sample_average_ascii_report_top: match");
        end
        else
        begin
            $display("sample_average_ascii_report_top: mismatch");
        end
        $finish;
    end

endmodule

>>> sample_average_ascii_report_top.f
+incdir+rtl/core
rtl/core/saar_pkg.sv
rtl/core/saar_ifs.sv
rtl/core/saar_front.sv
rtl/core/saar_queue.sv
rtl/core/saar_back.sv
rtl/core/sample_average_ascii_report_top.sv
sim/tb_sample_average_ascii_report_top.sv
